[src/rawrs_pkg.sv]
// shared types and constants for the read-ahead window request splitter
package rawrs_pkg;

   localparam int SECTOR_W = 48;
   localparam int COUNT_W  = 14;
   localparam int DISK_W   = 49;
   localparam int LENGTH_W = 8;
   localparam int WOFF_W   = 7;
   localparam int BOFF_W   = 13;
   localparam int FILL_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam int WINDOW_SECTORS      = 128;
   localparam int CHUNK_SECTORS       = 128;
   localparam int MAX_REQUEST_SECTORS = 8192;
   localparam int MAX_RESULTS         = 64;
   localparam int MAX_CHUNK_TOTAL     = MAX_RESULTS * CHUNK_SECTORS;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [DISK_W-1:0] DISK_RESET = '0;
   localparam logic [DISK_W-1:0] SPACE_LIMIT = DISK_W'(1) << SECTOR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISK_SECTORS   = 1'b0,
      CSR_WINDOW_ENABLED = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_HIT    = 2'd0,
      STATUS_REFILL = 2'd1,
      STATUS_DIRECT = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] start_sector;
      logic [COUNT_W-1:0]  sector_total;
   } req_payload_type;

   typedef struct packed {
      status_type          status;
      logic                dma_issue;
      logic [SECTOR_W-1:0] dma_sector;
      logic [LENGTH_W-1:0] dma_length;
      logic                dma_to_window;
      logic [WOFF_W-1:0]   window_offset;
      logic [BOFF_W-1:0]   buffer_offset;
      logic                last_result;
   } rsp_payload_type;

   // classified request handed from the front to the back
   typedef struct packed {
      status_type          kind;
      logic [SECTOR_W-1:0] lba;
      logic [COUNT_W-1:0]  count;
      logic [WOFF_W-1:0]   woff;
      logic [FILL_W-1:0]   fill;
   } cmd_type;

endpackage

[src/rawrs_front.sv]
// request front: range checks, window lookup and window state update
module rawrs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rawrs_pkg::req_payload_type        req_payload,
   input  logic [rawrs_pkg::DISK_W-1:0]      disk_sectors,
   input  logic                              window_enabled,
   output logic                              push_valid,
   input  logic                              push_ready,
   output rawrs_pkg::cmd_type                push_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CHECK  = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   rawrs_pkg::req_payload_type req_ff;
   logic [rawrs_pkg::DISK_W-1:0]   left_ff;
   logic                           past_end_ff;
   logic                           hit_ff;
   logic [rawrs_pkg::WOFF_W-1:0]   off_ff;

   logic                             window_valid_ff, window_valid_in;
   logic [rawrs_pkg::SECTOR_W-1:0]   window_base_ff, window_base_in;
   logic [rawrs_pkg::FILL_W-1:0]     window_fill_ff, window_fill_in;

   logic [rawrs_pkg::DISK_W-1:0]   disk_clamped;
   logic [rawrs_pkg::DISK_W:0]     left_full;
   logic [rawrs_pkg::SECTOR_W:0]   diff;
   logic [rawrs_pkg::FILL_W-1:0]   off8;
   logic [rawrs_pkg::FILL_W:0]     avail;
   logic                           hit_now;

   logic [rawrs_pkg::COUNT_W-1:0]  count;
   logic                           over_left;
   logic                           use_window;
   logic                           reject;
   logic [rawrs_pkg::FILL_W-1:0]   refill_fill;
   logic                           push_fire;

   // check stage: distance to disk end and offset into the window
   always_comb begin
      disk_clamped = (disk_sectors > rawrs_pkg::SPACE_LIMIT) ? rawrs_pkg::SPACE_LIMIT
                                                             : disk_sectors;
      left_full = {1'b0, disk_clamped} - {2'b00, req_ff.start_sector};
      diff = {1'b0, req_ff.start_sector} - {1'b0, window_base_ff};
      off8 = diff[rawrs_pkg::FILL_W-1:0];
      avail = {1'b0, window_fill_ff} - {1'b0, off8};
      hit_now = window_valid_ff && !diff[rawrs_pkg::SECTOR_W]
             && (diff[rawrs_pkg::SECTOR_W-1:rawrs_pkg::FILL_W] == '0)
             && (off8 < window_fill_ff)
             && (req_ff.sector_total <= {{(rawrs_pkg::COUNT_W-rawrs_pkg::FILL_W-1){1'b0}}, avail});
   end

   // decide stage: classify and build the command
   always_comb begin
      count = req_ff.sector_total;
      over_left = (left_ff[rawrs_pkg::DISK_W-1:rawrs_pkg::COUNT_W] == '0)
               && (count > left_ff[rawrs_pkg::COUNT_W-1:0]);
      use_window = (32'(count) <= rawrs_pkg::WINDOW_SECTORS) && window_enabled;
      reject = (count == '0)
            || (32'(count) > rawrs_pkg::MAX_REQUEST_SECTORS)
            || past_end_ff || over_left
            || (!use_window && (32'(count) > rawrs_pkg::MAX_CHUNK_TOTAL));
      refill_fill = (left_ff > rawrs_pkg::DISK_W'(rawrs_pkg::WINDOW_SECTORS))
                  ? rawrs_pkg::FILL_W'(rawrs_pkg::WINDOW_SECTORS)
                  : left_ff[rawrs_pkg::FILL_W-1:0];

      push_data.lba   = req_ff.start_sector;
      push_data.count = count;
      push_data.woff  = off_ff;
      push_data.fill  = refill_fill;
      priority if (reject) begin
         push_data.kind = rawrs_pkg::STATUS_REJECT;
      end else if (use_window && hit_ff) begin
         push_data.kind = rawrs_pkg::STATUS_HIT;
      end else if (use_window) begin
         push_data.kind = rawrs_pkg::STATUS_REFILL;
      end else begin
         push_data.kind = rawrs_pkg::STATUS_DIRECT;
      end
   end

   assign push_valid = (state_ff == ST_DECIDE);
   assign push_fire  = push_valid && push_ready;
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      window_valid_in = window_valid_ff;
      window_base_in  = window_base_ff;
      window_fill_in  = window_fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (push_fire) begin
               state_in = ST_IDLE;
               if (push_data.kind == rawrs_pkg::STATUS_REFILL) begin
                  window_valid_in = 1'b1;
                  window_base_in  = req_ff.start_sector;
                  window_fill_in  = refill_fill;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         window_valid_ff <= 1'b0;
         window_base_ff  <= '0;
         window_fill_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         window_valid_ff <= window_valid_in;
         window_base_ff  <= window_base_in;
         window_fill_ff  <= window_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_payload;
      end
      if (state_ff == ST_CHECK) begin
         left_ff     <= left_full[rawrs_pkg::DISK_W-1:0];
         past_end_ff <= left_full[rawrs_pkg::DISK_W] || (left_full[rawrs_pkg::DISK_W-1:0] == '0);
         hit_ff      <= hit_now;
         off_ff      <= off8[rawrs_pkg::WOFF_W-1:0];
      end
   end

endmodule

[src/rawrs_queue.sv]
// short command queue between front and back
module rawrs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rawrs_pkg::cmd_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rawrs_pkg::cmd_type pop_data
);

   localparam int PTR_W = (rawrs_pkg::QUEUE_DEPTH > 1) ? $clog2(rawrs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rawrs_pkg::QUEUE_DEPTH + 1);

   rawrs_pkg::cmd_type entry_ff [rawrs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(rawrs_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(rawrs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(rawrs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/rawrs_back.sv]
// result back end: one result beat per cycle while rsp_stall is low, direct requests split into chunks
module rawrs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  rawrs_pkg::cmd_type         pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rawrs_pkg::rsp_payload_type rsp_payload
);

   logic                              busy_ff, busy_in;
   rawrs_pkg::cmd_type                cmd_ff;
   logic [rawrs_pkg::SECTOR_W-1:0]    sector_ff;
   logic [rawrs_pkg::COUNT_W-1:0]     remaining_ff;
   logic [rawrs_pkg::BOFF_W-1:0]      done_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   rawrs_pkg::rsp_payload_type        rsp_ff;

   rawrs_pkg::rsp_payload_type        result;
   logic [rawrs_pkg::COUNT_W-1:0]     chunk;
   logic                              slot_free, emit, emit_last, pop;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && slot_free;
   assign emit_last = emit && result.last_result;
   assign pop       = pop_valid && (!busy_ff || emit_last);
   assign pop_ready = pop;

   always_comb begin
      chunk = (32'(remaining_ff) > rawrs_pkg::CHUNK_SECTORS)
            ? rawrs_pkg::COUNT_W'(rawrs_pkg::CHUNK_SECTORS) : remaining_ff;
      result = '0;
      result.status      = cmd_ff.kind;
      result.last_result = 1'b1;
      unique case (cmd_ff.kind)
         rawrs_pkg::STATUS_HIT: begin
            result.window_offset = cmd_ff.woff;
         end
         rawrs_pkg::STATUS_REFILL: begin
            result.dma_issue     = 1'b1;
            result.dma_sector    = cmd_ff.lba;
            result.dma_length    = cmd_ff.fill;
            result.dma_to_window = 1'b1;
         end
         rawrs_pkg::STATUS_DIRECT: begin
            result.dma_issue     = 1'b1;
            result.dma_sector    = sector_ff;
            result.dma_length    = chunk[rawrs_pkg::LENGTH_W-1:0];
            result.buffer_offset = done_ff;
            result.last_result   = (32'(remaining_ff) <= rawrs_pkg::CHUNK_SECTORS);
         end
         rawrs_pkg::STATUS_REJECT: begin
            result.last_result = 1'b1;
         end
         default: result.last_result = 1'b1;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      if (pop) begin
         busy_in = 1'b1;
      end else if (emit_last) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff       <= pop_data;
         sector_ff    <= pop_data.lba;
         remaining_ff <= pop_data.count;
         done_ff      <= '0;
      end else if (emit) begin
         sector_ff    <= sector_ff + rawrs_pkg::SECTOR_W'(chunk);
         remaining_ff <= remaining_ff - chunk;
         done_ff      <= done_ff + rawrs_pkg::BOFF_W'(chunk);
      end
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[src/readahead_window_request_splitter_core.sv]
// read-ahead window request splitter, top level
// The front takes a request beat through capture, range and window check, and
// classify; a window hit, window refill or reject then leaves as a single result
// beat, while a direct request leaves as ceil(sector_total / 128) chunk beats, one
// per cycle while rsp_stall is low. A two-entry command queue lets the front
// classify the next request while the back is still emitting chunks, so the rate
// of short requests is set by the front's check sequence, that of long requests by
// their chunk count. Window state lives in the front, updated when a refill is pushed.
// Configuration: index 0 is disk_sectors (49 bits, values past 2^48 act as 2^48),
// index 1 is window_enabled (bit 0); write only while no request is in flight.
module readahead_window_request_splitter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rawrs_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rawrs_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [rawrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rawrs_pkg::DISK_W-1:0]         csr_wdata
);

   logic [rawrs_pkg::DISK_W-1:0] disk_sectors_ff;
   logic                         window_enabled_ff;

   logic               push_valid, push_ready;
   rawrs_pkg::cmd_type push_data;
   logic               pop_valid, pop_ready;
   rawrs_pkg::cmd_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_sectors_ff   <= rawrs_pkg::DISK_RESET;
         window_enabled_ff <= 1'b1;
      end else if (csr_write_en) begin
         unique case (rawrs_pkg::csr_index_type'(csr_index))
            rawrs_pkg::CSR_DISK_SECTORS:   disk_sectors_ff   <= csr_wdata;
            rawrs_pkg::CSR_WINDOW_ENABLED: window_enabled_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   rawrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .disk_sectors   (disk_sectors_ff),
      .window_enabled (window_enabled_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   rawrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rawrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // front takes one request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("front accepted back-to-back requests");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == rawrs_pkg::STATUS_REJECT) |->
         (rsp_payload.last_result && !rsp_payload.dma_issue))
      else $error("reject beat not final or carries dma");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.dma_issue) |->
         (rsp_payload.dma_length != '0 &&
          32'(rsp_payload.dma_length) <= rawrs_pkg::CHUNK_SECTORS))
      else $error("dma beat with bad length");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.dma_to_window) |->
         (rsp_payload.status == rawrs_pkg::STATUS_REFILL))
      else $error("window fill outside a refill beat");

endmodule

[bench/testbench.sv]
// testbench for the read-ahead window request splitter: directed script, then random traffic
`timescale 1ns / 100ps

module testbench;
   import rawrs_pkg::*;

   localparam logic [SECTOR_W-1:0] LAST_SECTOR = '1;
   localparam logic [DISK_W-1:0]   DISK_MAX    = '1;
   localparam int                  SEGMENTS    = 6;
   localparam int                  SEGMENT_LEN = 60;

   typedef struct {
      bit                  is_csr;
      csr_index_type       csr_reg;
      logic [DISK_W-1:0]   csr_value;
      logic [SECTOR_W-1:0] start;
      int                  total;
      bit                  typed_reject;
   } script_row;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DISK_W-1:0]        csr_wdata = '0;

   // register and window state as the block should hold it
   logic [DISK_W-1:0]   disk_size = DISK_RESET;
   logic                window_on = 1'b1;
   logic                win_valid = 1'b0;
   logic [SECTOR_W-1:0] win_base = '0;
   logic [FILL_W-1:0]   win_fill = '0;

   rsp_payload_type split_beats [MAX_RESULTS];
   rsp_payload_type expected_beats [$];
   int              errors = 0;
   int              sender_idle_pct = 18;
   int              receiver_idle_pct = 78;

   // typed rows are rejects that can be read straight off the rules
   script_row directed_script [0:29] = '{
      '{1, CSR_DISK_SECTORS,   '0,          '0,   0,     0},
      '{0, CSR_DISK_SECTORS,   '0,          '0,   1,     1},
      '{1, CSR_DISK_SECTORS,   DISK_MAX,    '0,   0,     0},
      '{0, CSR_DISK_SECTORS,   '0,          '0,   0,     1},
      '{0, CSR_DISK_SECTORS,   '0,          '0,   16383, 1},
      '{0, CSR_DISK_SECTORS,   '0,          '0,   8193,  1},
      '{0, CSR_DISK_SECTORS,   '0,          LAST_SECTOR, 1, 0},
      '{0, CSR_DISK_SECTORS,   '0,          LAST_SECTOR, 1, 0},
      '{0, CSR_DISK_SECTORS,   '0,          LAST_SECTOR, 2, 1},
      '{0, CSR_DISK_SECTORS,   '0,          48'd1000, 128,  0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd1127, 1,    0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd1100, 28,   0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd1100, 29,   0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd999,  1,    0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd0,    129,  0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd5,    8192, 0},
      '{0, CSR_DISK_SECTORS,   '0,          LAST_SECTOR - 48'd8191, 8192, 0},
      '{1, CSR_WINDOW_ENABLED, 49'd0,       '0,   0,     0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd1000, 1,    0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd999,  1,    0},
      '{1, CSR_WINDOW_ENABLED, 49'd1,       '0,   0,     0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd999,  1,    0},
      '{1, CSR_DISK_SECTORS,   49'd300,     '0,   0,     0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd250,  10,   0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd260,  40,   0},
      '{0, CSR_DISK_SECTORS,   '0,          48'd300,  1,    1},
      '{0, CSR_DISK_SECTORS,   '0,          48'd299,  2,    1},
      '{0, CSR_DISK_SECTORS,   '0,          48'd0,    300,  0},
      '{1, CSR_DISK_SECTORS,   SPACE_LIMIT, '0,   0,     0},
      '{0, CSR_DISK_SECTORS,   '0,          LAST_SECTOR, 1, 0}
   };

   readahead_window_request_splitter_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // fills split_beats with the result beats of one request, returns how many
   function automatic int split_request(input req_payload_type item);
      logic [DISK_W-1:0] disk;
      logic [DISK_W-1:0] lba;
      logic [DISK_W-1:0] left;
      logic [DISK_W-1:0] off;
      rsp_payload_type   beat;
      int                count;
      int                done;
      int                chunk;
      int                n;
      lba = {1'b0, item.start_sector};
      count = item.sector_total;
      disk = (disk_size > SPACE_LIMIT) ? SPACE_LIMIT : disk_size;
      beat = '0;
      beat.last_result = 1'b1;
      if (count == 0 || count > MAX_REQUEST_SECTORS || lba >= disk || count > disk - lba) begin
         beat.status = STATUS_REJECT;
         split_beats[0] = beat;
         return 1;
      end
      left = disk - lba;
      if (count <= WINDOW_SECTORS && window_on) begin
         off = lba - {1'b0, win_base};
         if (win_valid && lba >= {1'b0, win_base} && off < win_fill
             && count <= win_fill - off) begin
            beat.status = STATUS_HIT;
            beat.window_offset = WOFF_W'(off);
         end else begin
            win_fill = (left > WINDOW_SECTORS) ? FILL_W'(WINDOW_SECTORS) : FILL_W'(left);
            win_base = item.start_sector;
            win_valid = 1'b1;
            beat.status = STATUS_REFILL;
            beat.dma_issue = 1'b1;
            beat.dma_sector = item.start_sector;
            beat.dma_length = LENGTH_W'(win_fill);
            beat.dma_to_window = 1'b1;
         end
         split_beats[0] = beat;
         return 1;
      end
      if ((count + CHUNK_SECTORS - 1) / CHUNK_SECTORS > MAX_RESULTS) begin
         beat.status = STATUS_REJECT;
         split_beats[0] = beat;
         return 1;
      end
      done = 0;
      n = 0;
      while (done < count) begin
         chunk = (count - done > CHUNK_SECTORS) ? CHUNK_SECTORS : count - done;
         beat = '0;
         beat.status = STATUS_DIRECT;
         beat.dma_issue = 1'b1;
         beat.dma_sector = item.start_sector + SECTOR_W'(done);
         beat.dma_length = LENGTH_W'(chunk);
         beat.buffer_offset = BOFF_W'(done);
         done += chunk;
         beat.last_result = (done == count);
         split_beats[n] = beat;
         n++;
      end
      return n;
   endfunction

   // mostly well-formed traffic around the window and the disk end, some noise
   function automatic req_payload_type pick_request();
      req_payload_type   item;
      logic [DISK_W-1:0] disk;
      logic [63:0]       wide;
      int                roll;
      int                total;
      disk = (disk_size > SPACE_LIMIT) ? SPACE_LIMIT : disk_size;
      wide = {$urandom(), $urandom()};
      roll = $urandom_range(99);
      if (disk == 0 || roll < 10) begin
         item.start_sector = wide[SECTOR_W-1:0];
         item.sector_total = COUNT_W'($urandom_range(16383));
      end else if (roll < 45) begin
         item.start_sector = win_base + SECTOR_W'($urandom_range(135));
         item.sector_total = COUNT_W'($urandom_range(1, 48));
      end else if (roll < 70) begin
         item.start_sector = SECTOR_W'(wide % disk);
         item.sector_total = COUNT_W'($urandom_range(1, WINDOW_SECTORS));
      end else if (roll < 85) begin
         // a few of the largest requests, most of them a handful of chunks
         total = ($urandom_range(14) == 0) ? $urandom_range(7000, MAX_REQUEST_SECTORS)
                                           : $urandom_range(129, 700);
         item.sector_total = COUNT_W'(total);
         item.start_sector = (disk > total) ? SECTOR_W'(wide % (disk - total + 1))
                                            : SECTOR_W'(wide % disk);
      end else begin
         item.sector_total = COUNT_W'($urandom_range(1, 300));
         item.start_sector = SECTOR_W'(disk - DISK_W'($urandom_range(1, 300)));
      end
      return item;
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DISK_W-1:0] value);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_DISK_SECTORS)
         disk_size = value;
      else
         window_on = value[0];
      @(posedge clock);
   endtask

   task automatic send_request(input req_payload_type item, input bit typed_reject);
      rsp_payload_type beat;
      int              n;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      n = split_request(item);
      if (typed_reject) begin
         beat = '0;
         beat.status = STATUS_REJECT;
         beat.last_result = 1'b1;
         expected_beats.push_back(beat);
      end else begin
         for (int k = 0; k < n; k++)
            expected_beats.push_back(split_beats[k]);
      end
   endtask

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("result beat with none expected: %p", rsp_payload);
            errors++;
         end else begin
            want = expected_beats.pop_front();
            compare_field("status", want.status, rsp_payload.status);
            compare_field("dma_issue", want.dma_issue, rsp_payload.dma_issue);
            compare_field("dma_sector", want.dma_sector, rsp_payload.dma_sector);
            compare_field("dma_length", want.dma_length, rsp_payload.dma_length);
            compare_field("dma_to_window", want.dma_to_window, rsp_payload.dma_to_window);
            compare_field("window_offset", want.window_offset, rsp_payload.window_offset);
            compare_field("buffer_offset", want.buffer_offset, rsp_payload.buffer_offset);
            compare_field("last_result", want.last_result, rsp_payload.last_result);
         end
      end
   end

   initial begin
      req_payload_type item;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         if (directed_script[i].is_csr) begin
            write_csr(directed_script[i].csr_reg, directed_script[i].csr_value);
         end else begin
            item.start_sector = directed_script[i].start;
            item.sector_total = COUNT_W'(directed_script[i].total);
            send_request(item, directed_script[i].typed_reject);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin
               sender_idle_pct = 18;
               receiver_idle_pct = 78;
            end
            1: begin
               sender_idle_pct = 78;
               receiver_idle_pct = 18;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         case (seg)
            0, 5:    write_csr(CSR_DISK_SECTORS, DISK_W'({$urandom(), $urandom()}) % SPACE_LIMIT);
            1:       write_csr(CSR_DISK_SECTORS, DISK_MAX);
            2:       write_csr(CSR_DISK_SECTORS, DISK_W'($urandom_range(1, 5000)));
            3:       write_csr(CSR_DISK_SECTORS, SPACE_LIMIT);
            default: write_csr(CSR_DISK_SECTORS, DISK_W'($urandom_range(129, 20000)));
         endcase
         write_csr(CSR_WINDOW_ENABLED, (seg == 2 || seg == 5) ? 49'd0 : 49'd1);
         for (int n = 0; n < SEGMENT_LEN; n++) begin
            // hold the sender off until everything outstanding has come back
            if (seg == 1 && n == SEGMENT_LEN / 2)
               drain_results();
            send_request(pick_request(), 1'b0);
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("readahead_window_request_splitter_core: match");
      else
         $display("readahead_window_request_splitter_core: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("readahead_window_request_splitter_core: mismatch");
      $finish;
   end

endmodule
